### sv/quadratic_bezier_pose_defines.svh
// Assertion macros shared by the quadratic Bezier pose block.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef QUADRATIC_BEZIER_POSE_DEFINES_SVH
`define QUADRATIC_BEZIER_POSE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BZP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BZP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bzp_pkg.sv
// Package of the quadratic Bezier pose block: widths, types, constants
// and the CORDIC arctangent table. No dependencies.
package bzp_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_COUNT    = 24;
    localparam int N_ST = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;

    localparam int T_W       = 17;  // curve parameter
    localparam int W_W       = 33;  // Bernstein weight, Q1.32, up to 2^32
    localparam int POS_W     = 32;
    localparam int ANG_W     = 20;
    localparam int CFG_W     = 32;
    localparam int ADDR_W    = 3;
    localparam int PSUM_W    = 67;  // position product and blend sum
    localparam int APROD_W   = 54;  // angle product
    localparam int ASUM_W    = 55;  // angle blend sum
    localparam int H_W       = 39;  // CORDIC angle accumulator, Q.30
    localparam int XY_W      = 34;  // CORDIC x and y, Q2.30
    localparam int Q15_W     = 16;

    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    typedef logic signed [H_W-1:0] t_angle;

    localparam t_angle HALF_PI_Q31 = 39'sd3373259426;
    localparam t_angle HALF_PI     = 39'sd1686629713;
    localparam t_angle PI          = 39'sd3373259426;
    localparam t_angle TWO_PI      = 39'sd6746518852;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [ADDR_W-1:0] {
        REG_START_X     = 3'd0,
        REG_START_Z     = 3'd1,
        REG_END_X       = 3'd2,
        REG_END_Z       = 3'd3,
        REG_CTRL_X      = 3'd4,
        REG_CTRL_Z      = 3'd5,
        REG_START_ANGLE = 3'd6,
        REG_CTRL_ANGLE  = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_z;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_z;
        logic signed [POS_W-1:0] ctrl_x;
        logic signed [POS_W-1:0] ctrl_z;
        logic signed [ANG_W-1:0] start_angle;
        logic signed [ANG_W-1:0] ctrl_angle;
    } t_cfg;

    typedef struct packed {
        logic [W_W-1:0] b0;
        logic [W_W-1:0] b1;
        logic [W_W-1:0] b2;
    } t_weights;

    typedef struct packed {
        logic signed [PSUM_W-1:0] x_sum;
        logic signed [PSUM_W-1:0] z_sum;
        logic signed [ASUM_W-1:0] a_sum;
    } t_sums;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_z;
        t_angle                  h;
        logic                    flip;
    } t_half_angle;

    // atan(2^-i) in Q2.30
    function automatic t_angle atan_q30(input int unsigned idx);
        t_angle v;
        case (idx)
            0:       v = 39'sd843314857;
            1:       v = 39'sd497837829;
            2:       v = 39'sd263043837;
            3:       v = 39'sd133525159;
            4:       v = 39'sd67021687;
            5:       v = 39'sd33543516;
            6:       v = 39'sd16775851;
            7:       v = 39'sd8388437;
            8:       v = 39'sd4194283;
            9:       v = 39'sd2097149;
            10:      v = 39'sd1048576;
            11:      v = 39'sd524288;
            12:      v = 39'sd262144;
            13:      v = 39'sd131072;
            14:      v = 39'sd65536;
            15:      v = 39'sd32768;
            16:      v = 39'sd16384;
            17:      v = 39'sd8192;
            18:      v = 39'sd4096;
            19:      v = 39'sd2048;
            20:      v = 39'sd1024;
            21:      v = 39'sd512;
            22:      v = 39'sd256;
            23:      v = 39'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/bzp_weights.sv
// Bernstein weight stage: clamps t and forms (1-t)^2, 2t(1-t) and t^2.
// Depends on bzp_pkg.
module bzp_weights import bzp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [T_W-1:0] i_param,
    output logic           o_valid,
    input  logic           i_ready,
    output t_weights       o_weights
);

    logic             r_valid;
    t_weights         r_weights;
    t_weights         n_weights;
    logic [T_W-1:0]   w_t;
    logic [T_W-1:0]   w_u;
    logic [2*T_W-1:0] w_uu;
    logic [2*T_W-1:0] w_tu;
    logic [2*T_W-1:0] w_tt;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_t  = (i_param > T_ONE) ? T_ONE : i_param;
        w_u  = T_ONE - w_t;
        w_uu = w_u * w_u;
        w_tu = w_t * w_u;
        w_tt = w_t * w_t;
        n_weights.b0 = w_uu[W_W-1:0];
        n_weights.b1 = {w_tu[W_W-2:0], 1'b0};
        n_weights.b2 = w_tt[W_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_weights <= n_weights;
        end
    end

    assign o_valid   = r_valid;
    assign o_weights = r_weights;

endmodule

### sv/bzp_blend.sv
// Blend stages: multiplies the weights with the configured points and
// angles, then sums the products. Depends on bzp_pkg.
module bzp_blend import bzp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_weights i_weights,
    output logic     o_valid,
    input  logic     i_ready,
    output t_sums    o_sums
);

    // products stage
    logic                      r_pv;
    logic signed [PSUM_W-1:0]  r_px [3];
    logic signed [PSUM_W-1:0]  r_pz [3];
    logic signed [APROD_W-1:0] r_pa [2];
    logic signed [PSUM_W-1:0]  n_px [3];
    logic signed [PSUM_W-1:0]  n_pz [3];
    logic signed [APROD_W-1:0] n_pa [2];
    // sum stage
    logic                      r_sv;
    t_sums                     r_sums;
    t_sums                     n_sums;
    logic                      w_rdy_p;
    logic                      w_rdy_s;
    logic signed [W_W:0]       w_b0;
    logic signed [W_W:0]       w_b1;
    logic signed [W_W:0]       w_b2;
    logic signed [POS_W:0]     w_cx;

    assign w_rdy_s = !r_sv || i_ready;
    assign w_rdy_p = !r_pv || w_rdy_s;
    assign o_ready = w_rdy_p;

    always_comb begin
        w_b0 = $signed({1'b0, i_weights.b0});
        w_b1 = $signed({1'b0, i_weights.b1});
        w_b2 = $signed({1'b0, i_weights.b2});
        // the control x point is the negated register value
        w_cx = -$signed({i_cfg.ctrl_x[POS_W-1], i_cfg.ctrl_x});
        n_px[0] = PSUM_W'(i_cfg.start_x * w_b0);
        n_px[1] = PSUM_W'(w_cx * w_b1);
        n_px[2] = PSUM_W'(i_cfg.end_x * w_b2);
        n_pz[0] = PSUM_W'(i_cfg.start_z * w_b0);
        n_pz[1] = PSUM_W'(i_cfg.ctrl_z * w_b1);
        n_pz[2] = PSUM_W'(i_cfg.end_z * w_b2);
        n_pa[0] = APROD_W'(i_cfg.start_angle * w_b0);
        n_pa[1] = APROD_W'(i_cfg.ctrl_angle * w_b1);
    end

    always_comb begin
        n_sums.x_sum = r_px[0] + r_px[1] + r_px[2];
        n_sums.z_sum = r_pz[0] + r_pz[1] + r_pz[2];
        n_sums.a_sum = ASUM_W'(r_pa[0]) + ASUM_W'(r_pa[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (w_rdy_p) begin
                r_pv <= i_valid;
            end
            if (w_rdy_s) begin
                r_sv <= r_pv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_p && i_valid) begin
            r_px <= n_px;
            r_pz <= n_pz;
            r_pa <= n_pa;
        end
        if (w_rdy_s && r_pv) begin
            r_sums <= n_sums;
        end
    end

    assign o_valid = r_sv;
    assign o_sums  = r_sums;

endmodule

### sv/bzp_angle.sv
// Rounding and angle range reduction: rounds and saturates the positions,
// offsets the angle by pi/2 and folds it into [-pi/2, pi/2]. Depends on bzp_pkg.
module bzp_angle import bzp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_sums       i_sums,
    output logic        o_valid,
    input  logic        i_ready,
    output t_half_angle o_half
);

    localparam int RP_W = PSUM_W - 32;

    logic              r_v [3];
    t_half_angle       r_st [3];
    t_half_angle       n_st [3];
    logic              w_rdy [4];
    logic signed [ASUM_W:0] w_a;

    // round to nearest with ties up, then saturate to 32 bits
    function automatic logic signed [POS_W-1:0] round_pos(input logic signed [PSUM_W-1:0] p);
        logic signed [PSUM_W-1:0] s;
        logic signed [RP_W-1:0]   r;
        s = p + PSUM_W'(64'sd2147483648);
        r = RP_W'(s >>> 32);
        if (r > RP_W'(64'sd2147483647)) begin
            return POS_W'(32'h7FFF_FFFF);
        end else if (r < -RP_W'(64'sd2147483648)) begin
            return POS_W'(32'h8000_0000);
        end
        return r[POS_W-1:0];
    endfunction

    assign w_rdy[3] = !r_v[2] || i_ready;
    assign w_rdy[2] = !r_v[2] || w_rdy[3];
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];

    always_comb begin
        // offset by pi/2; the angle in Q.31 reads as its double in Q.30
        w_a = {i_sums.a_sum[ASUM_W-1], i_sums.a_sum} + (ASUM_W+1)'(65536);
        n_st[0].pos_x = round_pos(i_sums.x_sum);
        n_st[0].pos_z = round_pos(i_sums.z_sum);
        n_st[0].h     = t_angle'(w_a >>> 17) + HALF_PI_Q31;
        n_st[0].flip  = 1'b0;

        // wrap by a whole turn
        n_st[1] = r_st[0];
        if (r_st[0].h > PI) begin
            n_st[1].h = r_st[0].h - TWO_PI;
        end else if (r_st[0].h < -PI) begin
            n_st[1].h = r_st[0].h + TWO_PI;
        end

        // fold by a half turn, which flips the sign of both outputs
        n_st[2] = r_st[1];
        if (r_st[1].h > HALF_PI) begin
            n_st[2].h    = r_st[1].h - PI;
            n_st[2].flip = 1'b1;
        end else if (r_st[1].h < -HALF_PI) begin
            n_st[2].h    = r_st[1].h + PI;
            n_st[2].flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
            r_v[2] <= 1'b0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_v[1] <= r_v[0];
            end
            if (w_rdy[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_st[0] <= n_st[0];
        end
        if (w_rdy[1] && r_v[0]) begin
            r_st[1] <= n_st[1];
        end
        if (w_rdy[2] && r_v[1]) begin
            r_st[2] <= n_st[2];
        end
    end

    assign o_valid = r_v[2];
    assign o_half  = r_st[2];

endmodule

### sv/bzp_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, followed by the
// output register that rounds to Q1.15. Depends on bzp_pkg.
module bzp_cordic import bzp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_half_angle             i_half,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [POS_W-1:0] o_pos_x,
    output logic signed [POS_W-1:0] o_pos_z,
    output logic signed [Q15_W-1:0] o_quat_w,
    output logic signed [Q15_W-1:0] o_quat_y
);

    localparam int QR_W = XY_W + 2 - 15;

    logic                    r_valid [N_ST];
    logic signed [XY_W-1:0]  r_x     [N_ST];
    logic signed [XY_W-1:0]  r_y     [N_ST];
    t_half_angle             r_st    [N_ST];
    logic                    w_rdy   [N_ST+1];
    logic                    w_v_in  [N_ST];
    logic signed [XY_W-1:0]  w_x_in  [N_ST];
    logic signed [XY_W-1:0]  w_y_in  [N_ST];
    t_half_angle             w_st_in [N_ST];

    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_z;
    logic signed [Q15_W-1:0] r_quat_w;
    logic signed [Q15_W-1:0] r_quat_y;
    logic signed [XY_W:0]    w_xe;
    logic signed [XY_W:0]    w_ye;
    logic signed [XY_W:0]    w_xf;
    logic signed [XY_W:0]    w_yf;

    // Q2.30 to Q1.15, round to nearest with ties up, saturate
    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [XY_W:0] v);
        logic signed [XY_W+1:0] s;
        logic signed [QR_W-1:0] r;
        s = {v[XY_W], v} + (XY_W+2)'(16384);
        r = QR_W'(s >>> 15);
        if (r > QR_W'(32767)) begin
            return Q15_W'(16'h7FFF);
        end else if (r < -QR_W'(32768)) begin
            return Q15_W'(16'h8000);
        end
        return r[Q15_W-1:0];
    endfunction

    assign w_rdy[N_ST] = !r_out_valid || i_ready;
    assign o_ready     = w_rdy[0];

    genvar k;
    generate
        for (k = 0; k < N_ST; k++) begin : g_iter
            logic signed [XY_W-1:0] w_dx;
            logic signed [XY_W-1:0] w_dy;
            logic signed [XY_W-1:0] n_x;
            logic signed [XY_W-1:0] n_y;
            t_half_angle            n_st;

            if (k == 0) begin : g_first
                assign w_v_in[k]  = i_valid;
                assign w_x_in[k]  = CORDIC_GAIN;
                assign w_y_in[k]  = '0;
                assign w_st_in[k] = i_half;
            end else begin : g_next
                assign w_v_in[k]  = r_valid[k-1];
                assign w_x_in[k]  = r_x[k-1];
                assign w_y_in[k]  = r_y[k-1];
                assign w_st_in[k] = r_st[k-1];
            end

            assign w_rdy[k] = !r_valid[k] || w_rdy[k+1];

            always_comb begin
                w_dx = w_y_in[k] >>> k;
                w_dy = w_x_in[k] >>> k;
                n_st = w_st_in[k];
                if (!w_st_in[k].h[H_W-1]) begin
                    n_x    = w_x_in[k] - w_dx;
                    n_y    = w_y_in[k] + w_dy;
                    n_st.h = w_st_in[k].h - atan_q30(k);
                end else begin
                    n_x    = w_x_in[k] + w_dx;
                    n_y    = w_y_in[k] - w_dy;
                    n_st.h = w_st_in[k].h + atan_q30(k);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (w_rdy[k]) begin
                    r_valid[k] <= w_v_in[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_rdy[k] && w_v_in[k]) begin
                    r_x[k]  <= n_x;
                    r_y[k]  <= n_y;
                    r_st[k] <= n_st;
                end
            end
        end
    endgenerate

    // w = cos(phi/2), y = -sin(phi/2); the half-turn fold negates both
    always_comb begin
        w_xe = {r_x[N_ST-1][XY_W-1], r_x[N_ST-1]};
        w_ye = {r_y[N_ST-1][XY_W-1], r_y[N_ST-1]};
        w_xf = r_st[N_ST-1].flip ? -w_xe : w_xe;
        w_yf = r_st[N_ST-1].flip ? w_ye : -w_ye;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy[N_ST]) begin
            r_out_valid <= r_valid[N_ST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[N_ST] && r_valid[N_ST-1]) begin
            r_pos_x  <= r_st[N_ST-1].pos_x;
            r_pos_z  <= r_st[N_ST-1].pos_z;
            r_quat_w <= to_q15(w_xf);
            r_quat_y <= to_q15(w_yf);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_pos_x  = r_pos_x;
    assign o_pos_z  = r_pos_z;
    assign o_quat_w = r_quat_w;
    assign o_quat_y = r_quat_y;

endmodule

### sv/quadratic_bezier_pose.sv
// Channel     Direction  Word contents (lowest bit first)
// s_axis      in         curve_param[16:0], zero fill to 24 bits
// m_axis      out        pos_x[31:0], pos_z[63:32], quat_w[79:64], quat_y[95:80]
// cfg         in         write enable, register index, 32-bit write data
//
// One word can enter per clock cycle unless the pipeline is full and stalled. The
// stages are one weight stage, product and sum stages, three rounding and range
// reduction stages, N CORDIC iteration stages (N is 16 here) and the output
// register. Each stage holds its own valid bit and only waits when the stage
// after it is full and stalled, so bubbles close up and s_axis_tready stays
// high unless every stage holds a word. Reset is synchronous and active low;
// it empties the pipeline and clears all configuration registers to zero.
// Configuration must be written while no word is in flight.
//
// Top level of the quadratic Bezier pose block.
// Depends on bzp_pkg, bzp_weights, bzp_blend, bzp_angle, bzp_cordic and
// the assertion macros in quadratic_bezier_pose_defines.svh.
`include "quadratic_bezier_pose_defines.svh"

module quadratic_bezier_pose import bzp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // curve_param[16:0]
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [95:0]       m_axis_tdata    // pos_x, pos_z, quat_w, quat_y
);

    t_cfg        r_cfg;
    logic        w_wt_valid;
    logic        w_wt_ready;
    t_weights    w_weights;
    logic        w_bl_valid;
    logic        w_bl_ready;
    t_sums       w_sums;
    logic        w_an_valid;
    logic        w_an_ready;
    t_half_angle w_half;
    logic signed [POS_W-1:0] w_pos_x;
    logic signed [POS_W-1:0] w_pos_z;
    logic signed [Q15_W-1:0] w_quat_w;
    logic signed [Q15_W-1:0] w_quat_y;
    logic                    w_out_stall;
    logic signed [33:0]      w_norm;
    logic                    w_norm_ok;

    // Configuration registers. The angle registers keep the low 20 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_START_X:     r_cfg.start_x     <= i_cfg_data;
                REG_START_Z:     r_cfg.start_z     <= i_cfg_data;
                REG_END_X:       r_cfg.end_x       <= i_cfg_data;
                REG_END_Z:       r_cfg.end_z       <= i_cfg_data;
                REG_CTRL_X:      r_cfg.ctrl_x      <= i_cfg_data;
                REG_CTRL_Z:      r_cfg.ctrl_z      <= i_cfg_data;
                REG_START_ANGLE: r_cfg.start_angle <= i_cfg_data[ANG_W-1:0];
                REG_CTRL_ANGLE:  r_cfg.ctrl_angle  <= i_cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    // Bernstein weights of the clamped curve parameter.
    bzp_weights u_weights (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_param   (s_axis_tdata[T_W-1:0]),
        .o_valid   (w_wt_valid),
        .i_ready   (w_wt_ready),
        .o_weights (w_weights)
    );

    // Weighted blends of positions and angles.
    bzp_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (w_wt_valid),
        .o_ready   (w_wt_ready),
        .i_weights (w_weights),
        .o_valid   (w_bl_valid),
        .i_ready   (w_bl_ready),
        .o_sums    (w_sums)
    );

    // Position rounding and reduction of the half angle to [-pi/2, pi/2].
    bzp_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_bl_valid),
        .o_ready (w_bl_ready),
        .i_sums  (w_sums),
        .o_valid (w_an_valid),
        .i_ready (w_an_ready),
        .o_half  (w_half)
    );

    // Cosine and sine of the half angle; the last register drives m_axis.
    bzp_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_an_valid),
        .o_ready  (w_an_ready),
        .i_half   (w_half),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_pos_x  (w_pos_x),
        .o_pos_z  (w_pos_z),
        .o_quat_w (w_quat_w),
        .o_quat_y (w_quat_y)
    );

    assign m_axis_tdata = {w_quat_y, w_quat_w, w_pos_z, w_pos_x};

    // Terms of the checks below.
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_norm      = w_quat_w * w_quat_w + w_quat_y * w_quat_y;
    assign w_norm_ok   = (w_norm > 34'sd1073479680) && (w_norm < 34'sd1074003968);

    // The input side only stalls when the whole pipeline is full and blocked.
    `BZP_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready, w_out_stall, "input stall needless")
    `BZP_ASSERT_NXT(a_full_keeps_output, !s_axis_tready, m_axis_tvalid, "output word lost")
    // The quaternion stays of unit length, whatever the angle.
    `BZP_ASSERT_IMP(a_unit_norm, m_axis_tvalid, w_norm_ok, "quaternion is not of unit length")

endmodule

### bench/testbench.sv
// Self-checking testbench of the quadratic Bezier pose block.
// Depends on bzp_pkg for the register index enum and port widths; drives
// directed and random curve parameters and checks every pose word.
module testbench;
    import bzp_pkg::*;

    // Latency of the block: weight, product, sum and range stages plus the
    // CORDIC stages and the output register.
    localparam int PIPE_DEPTH  = 7 + CORDIC_STAGES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 72;

    // Angle constants of the predictor in Q.30 radians, and the CORDIC gain in Q2.30.
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint CORDIC_K    = 64'sd652032874;

    // One pose word as it leaves the block.
    typedef struct {
        logic [31:0] pos_x;
        logic [31:0] pos_z;
        logic [15:0] quat_w;
        logic [15:0] quat_y;
    } pose_t;

    // One row of the directed sequence: a register write or a curve parameter,
    // the latter optionally with positions known by inspection.
    typedef struct {
        bit          is_write;
        t_cfg_reg    sel;
        logic [31:0] value;
        logic [16:0] param;
        bit          typed;
        logic [31:0] want_x;
        logic [31:0] want_z;
    } curve_step_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata;   // curve_param[16:0], zero fill above
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [95:0]       m_axis_tdata;   // pos_x, pos_z, quat_w, quat_y

    // Arctangent of 2^-i in Q2.30, for i from 0 to 23.
    longint arctan_steps [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    logic [31:0] shadow_regs [8];       // our copy of the configuration
    pose_t       pending_poses [$];     // poses owed by the block, oldest first
    pose_t       popped_pose;
    curve_step_t curve_steps [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 35;
    int          sink_idle_pct = 72;

    quadratic_bezier_pose i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Round a Q16.48 blend to Q16.16, ties toward plus infinity, and clamp.
    function automatic logic [31:0] round_q16(logic signed [67:0] p);
        logic signed [67:0] r;
        r = (p + 68'sd2147483648) >>> 32;
        if (r > 68'sd2147483647) begin
            r = 68'sd2147483647;
        end else if (r < -68'sd2147483648) begin
            r = -68'sd2147483648;
        end
        return r[31:0];
    endfunction

    // Round a Q2.30 value to Q1.15, ties up, and clamp to 16 bits.
    function automatic logic [15:0] to_q15(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    // Pose that the block must return for one curve parameter under the
    // current configuration.
    function automatic pose_t predict_pose(logic [16:0] param);
        logic signed [67:0] tt, uu, w0, w1, w2;
        logic signed [67:0] sx, sz, ex, ez, cx, cz, sa, ca, blend;
        longint             h, x, y, dx, dy;
        bit                 flip;
        int                 n_stages;
        pose_t              r;
        tt = param;
        if (tt > 68'sd65536) begin
            tt = 68'sd65536;
        end
        uu = 68'sd65536 - tt;
        w0 = uu * uu;
        w1 = 2 * tt * uu;
        w2 = tt * tt;

        sx = $signed(shadow_regs[REG_START_X]);
        sz = $signed(shadow_regs[REG_START_Z]);
        ex = $signed(shadow_regs[REG_END_X]);
        ez = $signed(shadow_regs[REG_END_Z]);
        cx = -$signed(shadow_regs[REG_CTRL_X]);
        cz = $signed(shadow_regs[REG_CTRL_Z]);
        sa = $signed(shadow_regs[REG_START_ANGLE][19:0]);
        ca = $signed(shadow_regs[REG_CTRL_ANGLE][19:0]);

        r.pos_x = round_q16(sx * w0 + cx * w1 + ex * w2);
        r.pos_z = round_q16(sz * w0 + cz * w1 + ez * w2);

        // The end angle is zero, so only two terms enter the angle blend.
        blend = sa * w0 + ca * w1;
        h = longint'((blend + 68'sd65536) >>> 17) + PI_Q30;

        // One full-turn fold, then a half-turn fold that negates the result.
        flip = 1'b0;
        if (h > PI_Q30) begin
            h = h - TWO_PI_Q30;
        end else if (h < -PI_Q30) begin
            h = h + TWO_PI_Q30;
        end
        if (h > HALF_PI_Q30) begin
            h = h - PI_Q30;
            flip = 1'b1;
        end else if (h < -HALF_PI_Q30) begin
            h = h + PI_Q30;
            flip = 1'b1;
        end

        n_stages = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
        x = CORDIC_K;
        y = 0;
        for (int i = 0; i < n_stages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (h >= 0) begin
                x = x - dx;
                y = y + dy;
                h = h - arctan_steps[i];
            end else begin
                x = x + dx;
                y = y - dy;
                h = h + arctan_steps[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        r.quat_w = to_q15(x);
        r.quat_y = to_q15(-y);
        return r;
    endfunction

    // Writes one register while the block is idle; the enable is lowered in
    // the next cycle so that back-to-back writes never collide in one step.
    task automatic write_reg(t_cfg_reg sel, logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= sel;
        i_cfg_data <= value;
        shadow_regs[sel] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one curve parameter after a random gap and records the pose it
    // owes once the block takes the word. Typed positions replace predicted.
    task automatic push_param(logic [16:0] param, bit typed,
                              logic [31:0] want_x, logic [31:0] want_z);
        pose_t owed;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, param};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        owed = predict_pose(param);
        if (typed) begin
            owed.pos_x = want_x;
            owed.pos_z = want_z;
        end
        pending_poses.push_back(owed);
    endtask

    // Stops sending and waits until the pipeline has delivered everything.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_poses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic add_write(t_cfg_reg sel, logic [31:0] value);
        curve_step_t s;
        s = '{1'b1, sel, value, 17'd0, 1'b0, 32'd0, 32'd0};
        curve_steps.push_back(s);
    endtask

    task automatic add_param(logic [16:0] param);
        curve_step_t s;
        s = '{1'b0, REG_START_X, 32'd0, param, 1'b0, 32'd0, 32'd0};
        curve_steps.push_back(s);
    endtask

    task automatic add_typed(logic [16:0] param, logic [31:0] want_x,
                             logic [31:0] want_z);
        curve_step_t s;
        s = '{1'b0, REG_START_X, 32'd0, param, 1'b1, want_x, want_z};
        curve_steps.push_back(s);
    endtask

    // Register value for a random phase: extremes, zero, small or anything.
    function automatic logic [31:0] random_reg_value(bit is_angle);
        case ($urandom_range(0, 5))
            0: begin
                return is_angle ? 32'h0007FFFF : 32'h7FFFFFFF;
            end
            1: begin
                return is_angle ? 32'h00080000 : 32'h80000000;
            end
            2: begin
                return 32'd0;
            end
            3: begin
                return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    // Mostly in-range parameters, with the ends and out-of-range values
    // appearing often enough to exercise the clamp.
    function automatic logic [16:0] random_param();
        case ($urandom_range(0, 9))
            0: begin
                return 17'd0;
            end
            1: begin
                return 17'd65536;
            end
            2: begin
                return 17'($urandom_range(65537, 131071));
            end
            default: begin
                return 17'($urandom_range(0, 65536));
            end
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Receiver: checks each accepted pose word against the oldest one owed
    // and stalls at random with the current percentage.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_poses.size() == 0) begin
                $display("%0t: pose word %h arrived with none owed", $time,
                         m_axis_tdata);
                error_count++;
            end else begin
                popped_pose = pending_poses.pop_front();
                check_field("pos_x", popped_pose.pos_x, m_axis_tdata[31:0]);
                check_field("pos_z", popped_pose.pos_z, m_axis_tdata[63:32]);
                check_field("quat_w", {16'd0, popped_pose.quat_w},
                            {16'd0, m_axis_tdata[79:64]});
                check_field("quat_y", {16'd0, popped_pose.quat_y},
                            {16'd0, m_axis_tdata[95:80]});
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("quadratic_bezier_pose: mismatch");
            $finish;
        end
    end

    initial begin
        t_cfg_reg sel;
        bit       busy;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        for (int k = 0; k < 8; k++) begin
            shadow_regs[k] = 32'd0;
        end

        // Directed sequence. With every register cleared the positions are
        // zero whatever the parameter, including one clamped from above.
        add_typed(17'd0, 32'd0, 32'd0);
        add_typed(17'd65536, 32'd0, 32'd0);
        add_typed(17'd131071, 32'd0, 32'd0);
        add_param(17'd32768);

        // Extreme positions and angles; the angle write carries junk above
        // bit 19 that the block must drop. The ends of the curve reproduce
        // the start and end points exactly.
        add_write(REG_START_X, 32'h7FFFFFFF);
        add_write(REG_START_Z, 32'h12345678);
        add_write(REG_END_X, 32'h80000000);
        add_write(REG_END_Z, 32'hFEDCBA98);
        add_write(REG_CTRL_X, 32'h80000000);
        add_write(REG_CTRL_Z, 32'h7FFFFFFF);
        add_write(REG_START_ANGLE, 32'hFFF7FFFF);
        add_write(REG_CTRL_ANGLE, 32'h00080000);
        add_typed(17'd0, 32'h7FFFFFFF, 32'h12345678);
        add_typed(17'd65536, 32'h80000000, 32'hFEDCBA98);
        add_typed(17'd65537, 32'h80000000, 32'hFEDCBA98);
        add_param(17'd1);
        add_param(17'd16384);
        add_param(17'd32768);
        add_param(17'd65535);

        // The negated control x drives the midpoint past the top of the range,
        // and the z midpoint lands on an exact half that rounds up. The start
        // angle lies below minus pi after doubling and needs the full-turn fold.
        add_write(REG_END_X, 32'h7FFFFFFF);
        add_write(REG_START_Z, 32'd2);
        add_write(REG_END_Z, 32'd0);
        add_write(REG_CTRL_Z, 32'd0);
        add_write(REG_START_ANGLE, 32'h000C0000);
        add_write(REG_CTRL_ANGLE, 32'h00008000);
        add_typed(17'd0, 32'h7FFFFFFF, 32'd2);
        add_typed(17'd32768, 32'h7FFFFFFF, 32'd1);
        add_typed(17'd65536, 32'h7FFFFFFF, 32'd0);
        add_param(17'd8192);
        add_param(17'd40000);

        // A negative half rounds up to zero; a positive start angle takes
        // the fold from above pi.
        add_write(REG_START_Z, 32'hFFFFFFFE);
        add_write(REG_START_ANGLE, 32'h00020000);
        add_typed(17'd0, 32'h7FFFFFFF, 32'hFFFFFFFE);
        add_typed(17'd32768, 32'h7FFFFFFF, 32'd0);
        add_param(17'd24576);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        busy = 1'b0;
        foreach (curve_steps[k]) begin
            if (curve_steps[k].is_write) begin
                if (busy) begin
                    wait_idle();
                    busy = 1'b0;
                end
                write_reg(curve_steps[k].sel, curve_steps[k].value);
            end else begin
                push_param(curve_steps[k].param, curve_steps[k].typed,
                           curve_steps[k].want_x, curve_steps[k].want_z);
                busy = 1'b1;
            end
        end

        // Random phases: a fresh configuration each time, with the sender
        // slow and the receiver slower, then the reverse, then full rate.
        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            sel = sel.first();
            repeat (sel.num()) begin
                write_reg(sel, random_reg_value(sel == REG_START_ANGLE ||
                                                sel == REG_CTRL_ANGLE));
                sel = sel.next();
            end
            case (ph / 3)
                0: begin
                    src_idle_pct  = 35;
                    sink_idle_pct = 72;
                end
                1: begin
                    src_idle_pct  = 72;
                    sink_idle_pct = 35;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            repeat (PHASE_WORDS) push_param(random_param(), 1'b0, 32'd0, 32'd0);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("quadratic_bezier_pose: match");
        end else begin
            $display("quadratic_bezier_pose: mismatch");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+sv
sv/bzp_pkg.sv
sv/bzp_weights.sv
sv/bzp_blend.sv
sv/bzp_angle.sv
sv/bzp_cordic.sv
sv/quadratic_bezier_pose.sv
bench/testbench.sv
